FILE: design/bpp_pkg.sv
`timescale 1ns / 1ps

package bpp_pkg;

    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 5;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int REF_W    = 16;

    localparam logic [REF_W-1:0] REF_MAX = '1;

    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_CLOSE = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_HANDLE = 3'd1,
        ST_POOL_FULL  = 3'd2,
        ST_PIPE_FULL  = 3'd3,
        ST_PIPE_EMPTY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_BYTE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [BYTE_W-1:0]   data;
    } result_t;

endpackage

FILE: design/bpp_ram.sv
`timescale 1ns / 1ps

module bpp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bpp_seq.sv
`timescale 1ns / 1ps

module bpp_seq
    import bpp_pkg::*;
#(
    parameter int NUM_PIPES  = 16,
    parameter int PIPE_DEPTH = 1024,
    parameter int SLOT_W     = 4,
    parameter int PTR_W      = 10,
    parameter int CNT_W      = 11,
    parameter int BYTE_AW    = 14,
    parameter int REC_W      = 111
) (
    input  logic                clk,
    input  logic                rst_n,
    // input transaction
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [HANDLE_W-1:0] handle,
    input  logic [KEY_W-1:0]    name_key,
    input  logic [BYTE_W-1:0]   data_in,
    // result hand-off
    output logic                res_valid,
    input  logic                res_take,
    output result_t             res,
    // byte store
    output logic                byte_wr_en,
    output logic                byte_rd_en,
    output logic [BYTE_AW-1:0]  byte_addr,
    output logic [BYTE_W-1:0]   byte_wr_data,
    input  logic [BYTE_W-1:0]   byte_rd_data,
    // slot records
    output logic                rec_rd_en,
    output logic [SLOT_W-1:0]   rec_rd_addr,
    input  logic [REC_W-1:0]    rec_rd_data,
    output logic                rec_wr_en,
    output logic [SLOT_W-1:0]   rec_wr_addr,
    output logic [REC_W-1:0]    rec_wr_data
);

    localparam int ACT_W = $clog2(NUM_PIPES + 1);

    state_t                 state_reg, state_next;
    logic [NUM_PIPES-1:0]   active_reg;
    logic [ACT_W-1:0]       active_total_reg;

    opcode_t                op_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [BYTE_W-1:0]      din_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [BYTE_AW-1:0]     base_reg;
    logic [SLOT_W-1:0]      scan_idx_reg;
    logic                   free_found_reg;
    logic [SLOT_W-1:0]      free_idx_reg;
    result_t                res_reg;

    logic                   accept;
    logic [5:0]             handle_m1;
    logic [SLOT_W-1:0]      hslot;
    logic                   in_range;
    logic                   handle_ok;

    logic [KEY_W-1:0]       rd_key;
    logic [PTR_W-1:0]       rd_head;
    logic [PTR_W-1:0]       rd_tail;
    logic [CNT_W-1:0]       rd_fill;
    logic [REF_W-1:0]       rd_ref;

    logic                   scan_hit;
    logic                   scan_free;
    logic                   scan_last;
    logic [SLOT_W-1:0]      alloc_idx;
    logic                   alloc_ok;
    logic                   pipe_full;
    logic                   pipe_empty;
    logic [REF_W-1:0]       ref_inc;
    logic [REF_W-1:0]       ref_dec;
    logic [PTR_W-1:0]       head_bump;
    logic [PTR_W-1:0]       tail_bump;

    function automatic logic [HANDLE_W-1:0] hout_of(input logic [SLOT_W-1:0] idx);
        logic [6:0] t;
        t = 7'(idx) + 7'd1;
        return t[HANDLE_W-1:0];
    endfunction

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    assign handle_m1 = {1'b0, handle} - 6'd1;
    assign hslot     = handle_m1[SLOT_W-1:0];
    assign in_range  = (handle != '0) && ({2'b00, handle} <= 7'(NUM_PIPES));
    assign handle_ok = in_range && active_reg[hslot];

    assign {rd_key, rd_head, rd_tail, rd_fill, rd_ref} = rec_rd_data;

    assign scan_hit  = active_reg[scan_idx_reg] && (rd_key == key_reg);
    assign scan_free = !active_reg[scan_idx_reg];
    assign scan_last = (scan_idx_reg == SLOT_W'(NUM_PIPES - 1));
    assign alloc_idx = free_found_reg ? free_idx_reg : scan_idx_reg;
    assign alloc_ok  = free_found_reg || scan_free;

    assign pipe_full  = (rd_fill == CNT_W'(PIPE_DEPTH));
    assign pipe_empty = (rd_fill == '0);
    assign ref_inc    = (rd_ref == REF_MAX) ? rd_ref : rd_ref + REF_W'(1);
    assign ref_dec    = (rd_ref == '0) ? rd_ref : rd_ref - REF_W'(1);
    assign head_bump  = (rd_head == PTR_W'(PIPE_DEPTH - 1)) ? '0 : rd_head + PTR_W'(1);
    assign tail_bump  = (rd_tail == PTR_W'(PIPE_DEPTH - 1)) ? '0 : rd_tail + PTR_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode_t'(opcode) == OP_OPEN)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (handle_ok)
                    begin
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_READ && !pipe_empty)
                begin
                    state_next = S_BYTE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BYTE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory controls
    always_comb
    begin
        rec_rd_en    = 1'b0;
        rec_rd_addr  = '0;
        rec_wr_en    = 1'b0;
        rec_wr_addr  = slot_reg;
        rec_wr_data  = rec_rd_data;
        byte_wr_en   = 1'b0;
        byte_rd_en   = 1'b0;
        byte_addr    = base_reg + BYTE_AW'(rd_tail);
        byte_wr_data = din_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                rec_rd_en   = accept;
                rec_rd_addr = (opcode_t'(opcode) == OP_OPEN) ? '0 : hslot;
            end
            S_SCAN:
            begin
                rec_rd_en   = !scan_hit && !scan_last;
                rec_rd_addr = scan_idx_reg + SLOT_W'(1);
                if (scan_hit)
                begin
                    rec_wr_en   = 1'b1;
                    rec_wr_addr = scan_idx_reg;
                    rec_wr_data = {rd_key, rd_head, rd_tail, rd_fill, ref_inc};
                end
                else if (scan_last && alloc_ok)
                begin
                    rec_wr_en   = 1'b1;
                    rec_wr_addr = alloc_idx;
                    rec_wr_data = {key_reg, PTR_W'(0), PTR_W'(0), CNT_W'(0), REF_W'(1)};
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_WRITE:
                    begin
                        if (!pipe_full)
                        begin
                            byte_wr_en  = 1'b1;
                            rec_wr_en   = 1'b1;
                            rec_wr_data = {rd_key, rd_head, tail_bump,
                                           rd_fill + CNT_W'(1), rd_ref};
                        end
                    end
                    OP_READ:
                    begin
                        byte_addr = base_reg + BYTE_AW'(rd_head);
                        if (!pipe_empty)
                        begin
                            byte_rd_en  = 1'b1;
                            rec_wr_en   = 1'b1;
                            rec_wr_data = {rd_key, head_bump, rd_tail,
                                           rd_fill - CNT_W'(1), rd_ref};
                        end
                    end
                    OP_CLOSE:
                    begin
                        rec_wr_en   = 1'b1;
                        rec_wr_data = {rd_key, rd_head, rd_tail, rd_fill, ref_dec};
                    end
                    default:
                    begin
                        rec_wr_en = 1'b0;
                    end
                endcase
            end
            S_BYTE,
            S_DONE:
            begin
                rec_rd_en = 1'b0;
            end
            default:
            begin
                rec_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            active_reg       <= '0;
            active_total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SCAN && !scan_hit && scan_last && alloc_ok)
            begin
                active_reg[alloc_idx] <= 1'b1;
                active_total_reg      <= active_total_reg + ACT_W'(1);
            end
            else if (state_reg == S_EXEC && op_reg == OP_CLOSE && ref_dec == '0)
            begin
                active_reg[slot_reg] <= 1'b0;
                active_total_reg     <= active_total_reg - ACT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_reg         <= opcode_t'(opcode);
                    key_reg        <= name_key;
                    din_reg        <= data_in;
                    slot_reg       <= hslot;
                    base_reg       <= BYTE_AW'(hslot) * BYTE_AW'(PIPE_DEPTH);
                    scan_idx_reg   <= '0;
                    free_found_reg <= 1'b0;
                    res_reg        <= '{status: ST_BAD_HANDLE, handle: '0, data: '0};
                end
            end
            S_SCAN:
            begin
                scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                if (scan_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= scan_idx_reg;
                end
                if (scan_hit)
                begin
                    res_reg <= '{status: ST_OK, handle: hout_of(scan_idx_reg), data: '0};
                end
                else if (alloc_ok)
                begin
                    res_reg <= '{status: ST_OK, handle: hout_of(alloc_idx), data: '0};
                end
                else
                begin
                    res_reg <= '{status: ST_POOL_FULL, handle: '0, data: '0};
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_WRITE && pipe_full)
                begin
                    res_reg.status <= ST_PIPE_FULL;
                end
                else if (op_reg == OP_READ && pipe_empty)
                begin
                    res_reg.status <= ST_PIPE_EMPTY;
                end
                else
                begin
                    res_reg.status <= ST_OK;
                end
            end
            S_BYTE:
            begin
                res_reg.data <= byte_rd_data;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        active_total_reg == ACT_W'($countones(active_reg)))
        else $error("active total out of step with active flags");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg <= SLOT_W'(NUM_PIPES - 1)))
        else $error("scan index past last slot");

    a_pool_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_reg.status == ST_POOL_FULL) |-> (&active_reg))
        else $error("pool full reported with a free slot");

    a_exec_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> active_reg[slot_reg])
        else $error("byte or close transaction on inactive slot");

    a_byte_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BYTE) |-> $past(byte_rd_en))
        else $error("byte capture without a store read");

endmodule

FILE: design/byte_pipe_pool_top.sv
`timescale 1ns / 1ps
// Path to out_valid: a bad handle goes straight to the result; write and close read
// the slot record and execute; read adds a byte fetch; open scans the records, one
// slot record compared per cycle, until a key match or the last slot. One transaction
// in flight; the next is accepted once the sequencer is idle again after the result
// moves to the output register. Reset (async, active low) clears the sequencer state,
// active flags and output valid; byte store and slot records are not cleared.
module byte_pipe_pool_top
    import bpp_pkg::*;
#(
    parameter int NUM_PIPES  = 16,
    parameter int PIPE_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [HANDLE_W-1:0] handle,
    input  logic [KEY_W-1:0]    name_key,
    input  logic [BYTE_W-1:0]   data_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [HANDLE_W-1:0] handle_out,
    output logic [BYTE_W-1:0]   data_out
);

    localparam int SLOT_W     = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PTR_W      = $clog2(PIPE_DEPTH);
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);
    localparam int BYTE_DEPTH = NUM_PIPES * PIPE_DEPTH;
    localparam int BYTE_AW    = $clog2(BYTE_DEPTH);
    localparam int REC_W      = KEY_W + 2 * PTR_W + CNT_W + REF_W;

    logic               res_valid;
    logic               res_take;
    result_t            res;

    logic               byte_wr_en;
    logic               byte_rd_en;
    logic [BYTE_AW-1:0] byte_addr;
    logic [BYTE_W-1:0]  byte_wr_data;
    logic [BYTE_W-1:0]  byte_rd_data;

    logic               rec_rd_en;
    logic [SLOT_W-1:0]  rec_rd_addr;
    logic [REC_W-1:0]   rec_rd_data;
    logic               rec_wr_en;
    logic [SLOT_W-1:0]  rec_wr_addr;
    logic [REC_W-1:0]   rec_wr_data;

    logic               out_valid_reg;
    result_t            out_reg;

    bpp_seq #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_DEPTH (PIPE_DEPTH),
        .SLOT_W     (SLOT_W),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W),
        .BYTE_AW    (BYTE_AW),
        .REC_W      (REC_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .handle       (handle),
        .name_key     (name_key),
        .data_in      (data_in),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res),
        .byte_wr_en   (byte_wr_en),
        .byte_rd_en   (byte_rd_en),
        .byte_addr    (byte_addr),
        .byte_wr_data (byte_wr_data),
        .byte_rd_data (byte_rd_data),
        .rec_rd_en    (rec_rd_en),
        .rec_rd_addr  (rec_rd_addr),
        .rec_rd_data  (rec_rd_data),
        .rec_wr_en    (rec_wr_en),
        .rec_wr_addr  (rec_wr_addr),
        .rec_wr_data  (rec_wr_data)
    );

    bpp_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (BYTE_DEPTH),
        .ADDR_W (BYTE_AW)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_wr_en),
        .wr_addr (byte_addr),
        .wr_data (byte_wr_data),
        .rd_en   (byte_rd_en),
        .rd_addr (byte_addr),
        .rd_data (byte_rd_data)
    );

    bpp_ram #(
        .WIDTH  (REC_W),
        .DEPTH  (NUM_PIPES),
        .ADDR_W (SLOT_W)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (rec_wr_en),
        .wr_addr (rec_wr_addr),
        .wr_data (rec_wr_data),
        .rd_en   (rec_rd_en),
        .rd_addr (rec_rd_addr),
        .rd_data (rec_rd_data)
    );

    // output register decouples result from the next transaction
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign handle_out = out_reg.handle;
    assign data_out   = out_reg.data;

endmodule

FILE: tb/sv/byte_pipe_pool_tb.sv
`timescale 1ns / 1ps

module tb;
    import bpp_pkg::*;

    localparam int NUM_PIPES  = 16;
    localparam int PIPE_DEPTH = 1024;
    localparam int LONG_HOLD  = 60;
    localparam int RAND_ITEMS = 500;
    localparam logic [KEY_W-1:0] LAST_KEY = 64'h5A7E_0000_0000_0001;

    class pool_scoreboard;
        logic [BYTE_W-1:0]   bytes [NUM_PIPES][PIPE_DEPTH];
        logic [9:0]          head [NUM_PIPES];
        logic [9:0]          tail [NUM_PIPES];
        logic [10:0]         fill [NUM_PIPES];
        logic [REF_W-1:0]    refs [NUM_PIPES];
        bit                  active [NUM_PIPES];
        logic [KEY_W-1:0]    keys [NUM_PIPES];
        result_t             replies_due[$];
        int                  failures;

        function void accept_request(opcode_t op, logic [HANDLE_W-1:0] h,
                                     logic [KEY_W-1:0] key, logic [BYTE_W-1:0] d);
            result_t r;
            int s;
            bit found;
            r = '0;
            r.status = ST_OK;
            found = 1'b0;
            if (op == OP_OPEN)
            begin
                for (int i = 0; i < NUM_PIPES && !found; i++)
                begin
                    if (active[i] && keys[i] == key)
                    begin
                        if (refs[i] != REF_MAX)
                            refs[i]++;
                        r.handle = HANDLE_W'(i + 1);
                        found = 1'b1;
                    end
                end
                for (int i = 0; i < NUM_PIPES && !found; i++)
                begin
                    if (!active[i])
                    begin
                        active[i] = 1'b1;
                        keys[i] = key;
                        head[i] = '0;
                        tail[i] = '0;
                        fill[i] = '0;
                        refs[i] = REF_W'(1);
                        r.handle = HANDLE_W'(i + 1);
                        found = 1'b1;
                    end
                end
                if (!found)
                    r.status = ST_POOL_FULL;
            end
            else
            begin
                s = (h >= 1 && h <= NUM_PIPES && active[h - 1]) ? int'(h) - 1 : -1;
                if (s < 0)
                    r.status = ST_BAD_HANDLE;
                else if (op == OP_WRITE)
                begin
                    if (fill[s] >= PIPE_DEPTH)
                        r.status = ST_PIPE_FULL;
                    else
                    begin
                        bytes[s][tail[s]] = d;
                        tail[s] = (tail[s] == PIPE_DEPTH - 1) ? '0 : tail[s] + 1'b1;
                        fill[s]++;
                    end
                end
                else if (op == OP_READ)
                begin
                    if (fill[s] == 0)
                        r.status = ST_PIPE_EMPTY;
                    else
                    begin
                        r.data = bytes[s][head[s]];
                        head[s] = (head[s] == PIPE_DEPTH - 1) ? '0 : head[s] + 1'b1;
                        fill[s]--;
                    end
                end
                else
                begin
                    if (refs[s] > 0)
                        refs[s]--;
                    if (refs[s] == 0)
                        active[s] = 1'b0;
                end
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] ho,
                                  logic [BYTE_W-1:0] dout);
            result_t want;
            if (replies_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected transaction: status %0d handle %0d data %02h",
                             st, ho, dout);
                return;
            end
            want = replies_due.pop_front();
            if (want.status !== st || want.handle !== ho || want.data !== dout)
            begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch: expected status %0d handle %0d data %02h, ",
                              "got status %0d handle %0d data %02h"},
                             want.status, want.handle, want.data, st, ho, dout);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          opcode = '0;
    logic [HANDLE_W-1:0] handle = '0;
    logic [KEY_W-1:0]    name_key = '0;
    logic [BYTE_W-1:0]   data_in = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [BYTE_W-1:0]   data_out;

    bit idle_en = 1'b1;
    bit hold_request = 1'b0;
    int stall_left = 0;

    pool_scoreboard sb = new();

    byte_pipe_pool_top #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_DEPTH (PIPE_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .handle     (handle),
        .name_key   (name_key),
        .data_in    (data_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .handle_out (handle_out),
        .data_out   (data_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_reply(status, handle_out, data_out);
            if (in_valid && in_ready)
                sb.accept_request(opcode_t'(opcode), handle, name_key, data_in);
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue_request(opcode_t op, logic [HANDLE_W-1:0] h,
                                 logic [KEY_W-1:0] key, logic [BYTE_W-1:0] d);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        handle   <= h;
        name_key <= key;
        data_in  <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_pool();
        for (int i = 0; i < NUM_PIPES; i++)
        begin
            while (sb.active[i])
                issue_request(OP_CLOSE, HANDLE_W'(i + 1), '0, '0);
        end
    endtask

    initial
    begin
        #200_000_000;
        $display("byte_pipe_pool_top test failed");
        $finish;
    end

    initial
    begin
        logic [KEY_W-1:0]    key_pool [24];
        logic [HANDLE_W-1:0] h;
        logic [KEY_W-1:0]    key;
        opcode_t             op;
        int                  sel;
        int                  w;
        int                  live_q[$];

        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // bad and inactive handles
        issue_request(OP_WRITE, 5'd0, '0, 8'h11);
        issue_request(OP_READ, 5'd5, '0, '0);
        issue_request(OP_CLOSE, 5'd31, '1, '1);
        // open, reopen, empty pipe, byte order
        issue_request(OP_OPEN, 5'd0, '1, '0);
        issue_request(OP_OPEN, 5'd0, '0, '0);
        issue_request(OP_OPEN, 5'd3, '1, '0);
        issue_request(OP_READ, 5'd2, '0, '0);
        issue_request(OP_WRITE, 5'd1, '0, 8'hFF);
        issue_request(OP_WRITE, 5'd1, '0, 8'h00);
        issue_request(OP_WRITE, 5'd2, '0, 8'hA5);
        issue_request(OP_READ, 5'd1, '0, '0);
        issue_request(OP_READ, 5'd1, '0, '0);
        issue_request(OP_READ, 5'd1, '0, '0);
        // close keeps slot until last reference
        issue_request(OP_CLOSE, 5'd1, '0, '0);
        issue_request(OP_WRITE, 5'd1, '0, 8'h3C);
        issue_request(OP_CLOSE, 5'd1, '0, '0);
        issue_request(OP_WRITE, 5'd1, '0, 8'h3C);
        issue_request(OP_READ, 5'd1, '0, '0);
        issue_request(OP_OPEN, 5'd0, 64'h8000_0000_0000_0000, '0);
        // fill the pool, then one more key
        for (int i = 1; i <= NUM_PIPES - 2; i++)
            issue_request(OP_OPEN, 5'd0, KEY_W'(i), '0);
        issue_request(OP_OPEN, 5'd0, 64'h5555_5555_5555_5555, '0);
        issue_request(OP_WRITE, 5'd16, '0, 8'h5A);
        issue_request(OP_READ, 5'd16, '0, '0);
        issue_request(OP_OPEN, 5'd0, '0, '0);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 150)
                hold_request = 1'b1;
            live_q.delete();
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                if (sb.active[i])
                    live_q.push_back(i + 1);
            end
            sel = $urandom_range(0, 99);
            if (sel < 55 && live_q.size() > 0)
            begin
                h = HANDLE_W'(live_q[$urandom_range(0, live_q.size() - 1)]);
                w = $urandom_range(0, 9);
                if (w < 4)
                    issue_request(OP_WRITE, h, {$urandom, $urandom}, 8'($urandom));
                else if (w < 7)
                    issue_request(OP_READ, h, {$urandom, $urandom}, 8'($urandom));
                else if (w < 9)
                    issue_request(OP_CLOSE, h, {$urandom, $urandom}, 8'($urandom));
                else
                    issue_request(OP_OPEN, h, sb.keys[h - 1], 8'($urandom));
            end
            else if (sel < 75)
            begin
                key = key_pool[$urandom_range(0, 23)];
                issue_request(OP_OPEN, HANDLE_W'($urandom), key, 8'($urandom));
            end
            else
            begin
                op = opcode_t'($urandom_range(0, 3));
                issue_request(op, HANDLE_W'($urandom_range(0, 31)), {$urandom, $urandom},
                              8'($urandom));
            end
        end

        // no idling from here on
        idle_en = 1'b0;
        drain_pool();
        issue_request(OP_OPEN, '0, LAST_KEY, '0);
        issue_request(OP_WRITE, 5'd1, '0, 8'h77);
        issue_request(OP_READ, 5'd1, '0, '0);
        issue_request(OP_CLOSE, 5'd1, '0, '0);
        issue_request(OP_WRITE, 5'd1, '0, 8'h77);

        in_valid <= 1'b0;
        while (sb.replies_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.failures == 0)
            $display("byte_pipe_pool_top test passed");
        else
            $display("byte_pipe_pool_top test failed");
        $finish;
    end

endmodule
